@@ design/itap_pkg.sv @@
`timescale 1ns / 1ps

package itap_pkg;

   typedef enum logic [3:0] {
      PH_START  = 4'b0001,
      PH_ZERO   = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_OCT = 2'd1,
      RX_HEX = 2'd2
   } radix_type;

   // classified character as it travels through the queue
   typedef struct packed {
      logic       last;
      logic       is_dec;
      logic       is_zero;
      logic       is_x;
      logic       is_hexl;
      logic       is_dot;
      logic       is_term;
      logic [3:0] dig;
   } cls_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } q_stat_type;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;

   localparam logic [1:0] LAST_PART = 2'd3;

endpackage

@@ design/itap_req_if.sv @@
`timescale 1ns / 1ps

interface itap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       string_end;

   modport source (output valid, output char_code, output string_end, input ready);
   modport sink (input valid, input char_code, input string_end, output ready);
endinterface

@@ design/itap_rsp_if.sv @@
`timescale 1ns / 1ps

interface itap_rsp_if;
   logic        valid;
   logic        ready;
   logic        valid_res;
   logic [31:0] address;

   modport source (output valid, output valid_res, output address, input ready);
   modport sink (input valid, input valid_res, input address, output ready);
endinterface

@@ design/itap_front.sv @@
`timescale 1ns / 1ps

module itap_front (
   itap_req_if.sink          req,
   input  logic              q_full,
   output logic              push,
   output itap_pkg::cls_type cls
);
   import itap_pkg::*;

   logic [7:0] c;

   assign c        = req.char_code;
   assign req.ready = !q_full;
   assign push     = req.valid && !q_full;

   always_comb begin
      cls         = '0;
      cls.last    = req.string_end;
      cls.is_dec  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      cls.is_zero = (c == CHAR_ZERO);
      cls.is_x    = (c == CHAR_LOWER_X) || (c == CHAR_UPPER_X);
      cls.is_dot  = (c == CHAR_DOT);
      cls.is_term = (c == CHAR_NUL) || (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_F)) begin
         cls.is_hexl = 1'b1;
         cls.dig     = 4'(c - CHAR_LOWER_A + 8'd10);
      end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
         cls.is_hexl = 1'b1;
         cls.dig     = 4'(c - CHAR_UPPER_A + 8'd10);
      end else begin
         cls.dig     = c[3:0];
      end
   end
endmodule

@@ design/itap_queue.sv @@
`timescale 1ns / 1ps

module itap_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  itap_pkg::cls_type    push_data,
   input  logic                 pop,
   output itap_pkg::cls_type    head,
   output itap_pkg::q_stat_type stat
);
   import itap_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   cls_type          slot_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.not_empty = (count_ff != '0);
   assign stat.full      = (count_ff == FULL_CNT);
   assign head           = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IDX) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

@@ design/itap_back.sv @@
`timescale 1ns / 1ps

module itap_back (
   input  logic              clock,
   input  logic              reset,
   input  itap_pkg::cls_type head,
   input  logic              q_not_empty,
   output logic              pop,
   itap_rsp_if.source        rsp
);
   import itap_pkg::*;

   phase_type   phase_ff, ph1;
   radix_type   radix_ff, rx1;
   logic [31:0] acc_ff, acc1, acc_scaled;
   logic [1:0]  pc_ff, pc1;
   logic [31:0] ep_ff [3];

   logic        bad1, fin1, digits, ep_we;
   logic        fin_ok, use_fin, emit, res_ok;
   logic [31:0] fin_val;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        res_ok_ff;
   logic [31:0] addr_ff;

   assign pop = q_not_empty && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      case (radix_ff)
         RX_OCT:  acc_scaled = {acc_ff[28:0], 3'd0};
         RX_HEX:  acc_scaled = {acc_ff[27:0], 4'd0};
         default: acc_scaled = {acc_ff[28:0], 3'd0} + {acc_ff[30:0], 1'b0};
      endcase
   end

   // one character of the parse
   always_comb begin
      ph1    = phase_ff;
      rx1    = radix_ff;
      acc1   = acc_ff;
      pc1    = pc_ff;
      bad1   = 1'b0;
      fin1   = 1'b0;
      digits = 1'b0;
      ep_we  = 1'b0;
      unique case (phase_ff)
         PH_START: begin
            if (!head.is_dec) begin
               bad1 = 1'b1;
            end else if (head.is_zero) begin
               ph1  = PH_ZERO;
               rx1  = RX_OCT;
               acc1 = '0;
            end else begin
               ph1  = PH_DIGITS;
               rx1  = RX_DEC;
               acc1 = {28'd0, head.dig};
            end
         end
         PH_ZERO: begin
            ph1 = PH_DIGITS;
            if (head.is_x) begin
               rx1 = RX_HEX;
            end else begin
               digits = 1'b1;
            end
         end
         PH_DIGITS: begin
            digits = 1'b1;
         end
         default: begin
         end
      endcase
      if (digits) begin
         if (head.is_dec) begin
            acc1 = acc_scaled + {28'd0, head.dig};
         end else if ((radix_ff == RX_HEX) && head.is_hexl) begin
            acc1 = {acc_ff[27:0], head.dig};
         end else if (head.is_dot) begin
            if (pc_ff == LAST_PART) begin
               bad1 = 1'b1;
            end else begin
               ep_we = 1'b1;
               pc1   = pc_ff + 2'd1;
               acc1  = '0;
               rx1   = RX_DEC;
               ph1   = PH_START;
            end
         end else if (head.is_term) begin
            fin1 = 1'b1;
         end else begin
            bad1 = 1'b1;
         end
      end
      if (bad1 || fin1) begin
         ph1 = PH_DONE;
      end
   end

   // range check of the last part and merge of the earlier ones
   always_comb begin
      case (pc_ff)
         2'd0: begin
            fin_ok  = 1'b1;
            fin_val = acc1;
         end
         2'd1: begin
            fin_ok  = (acc1[31:24] == '0);
            fin_val = acc1 | (ep_ff[0] << 24);
         end
         2'd2: begin
            fin_ok  = (acc1[31:16] == '0);
            fin_val = acc1 | (ep_ff[0] << 24) | (ep_ff[1] << 16);
         end
         default: begin
            fin_ok  = (acc1[31:8] == '0);
            fin_val = acc1 | (ep_ff[0] << 24) | (ep_ff[1] << 16) | (ep_ff[2] << 8);
         end
      endcase
   end

   // end flag supplies an implied terminator when still undecided
   assign emit    = bad1 || fin1 || (head.last && (ph1 != PH_DONE));
   assign use_fin = fin1 || (head.last && (ph1 != PH_DONE) && (ph1 != PH_START));
   assign res_ok  = use_fin && fin_ok;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         radix_ff     <= RX_DEC;
         acc_ff       <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (head.last) begin
               phase_ff <= PH_START;
               radix_ff <= RX_DEC;
               acc_ff   <= '0;
               pc_ff    <= '0;
            end else begin
               phase_ff <= ph1;
               radix_ff <= rx1;
               acc_ff   <= acc1;
               pc_ff    <= pc1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && ep_we) begin
         ep_ff[pc_ff] <= acc_ff;
      end
      if (pop && emit) begin
         res_ok_ff <= res_ok;
         addr_ff   <= res_ok ? fin_val : '0;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.valid_res = res_ok_ff;
   assign rsp.address   = addr_ff;
endmodule

@@ design/ipv4_text_address_parser.sv @@
`timescale 1ns / 1ps

// Dotted IPv4 address text parser. One character is taken per transfer and
// the block sustains one character per clock cycle while the queue has room
// and results are accepted; the per-character parse update (radix
// multiply-add on the 32-bit part value) is a combinational step in the back
// end. A result for a character passes through the classification queue and
// then the result register. Each string gives exactly one result, on the
// character where it is decided (terminator, reject or end flag); later
// characters up to the end flag give none. Parts may be decimal, octal with a
// leading zero, or hex with 0x; with more than one part the address holds
// the first part in its top byte, and it is zero when valid_res is low.
module ipv4_text_address_parser #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic        clock,
   input logic        reset,
   itap_req_if.sink   req_ch,
   itap_rsp_if.source rsp_ch
);
   import itap_pkg::*;

   cls_type    front_cls;
   cls_type    q_head;
   q_stat_type q_stat;
   logic       q_push;
   logic       q_pop;

   itap_front u_front (
      .req    (req_ch),
      .q_full (q_stat.full),
      .push   (q_push),
      .cls    (front_cls)
   );

   itap_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_cls),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   itap_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .q_not_empty (q_stat.not_empty),
      .pop         (q_pop),
      .rsp         (rsp_ch)
   );

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   a_invalid_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.valid_res) |-> (rsp_ch.address == '0))
      else $error("rejected string with nonzero address");

   a_rsp_needs_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(q_stat.not_empty))
      else $error("result raised without a queued character");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (q_stat.full && !q_pop) |=> q_stat.full)
      else $error("queue left full state without a pop");
endmodule
